[rtl/core/tfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_pkg: shared types and constants for the thermal false-color core
// Field widths, quotient size, sequencer states and divider control.
// ----------------------------------------------------------------------------
package tfc_pkg;

    // fixed port field widths
    localparam int SAMPLE_W        = 16;
    localparam int COLOUR_W        = 16;

    // default number of significant sample bits
    localparam int SAMPLE_BITS_DEF = 16;

    // scaled value: 8-bit quotient, one bit resolved per cycle
    localparam int Q_W             = 8;
    localparam int CNT_W           = $clog2(Q_W);
    localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

    // top-level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } tfc_state_t;

    // divider launch control
    typedef struct packed {
        logic start;
        logic force_zero;
        logic force_max;
    } div_ctl_t;

endpackage
`default_nettype wire

[rtl/core/thermal_false_colour_rgb565_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item runs through the 8-step bit-serial divider, the
//   scaled value register and the output register; no new item is accepted
//   until the result is loaded into the output register, and a finished result
//   waits in the output register while the next item is accepted.
// Reset: asynchronous, active low; clears control, reference low/high to 0
//   (first frame maps to zero) and running low/high to all-ones/zero.
// ----------------------------------------------------------------------------
// thermal_false_colour_rgb565_core: autoranging false-color mapper
// Scales each sample against the previous frame's low/high, maps it to a
// blue-green-red ramp and emits byte-swapped RGB565.
// ----------------------------------------------------------------------------
module thermal_false_colour_rgb565_core #(
    parameter int SAMPLE_BITS = tfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [tfc_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  wire logic                            s_axis_tlast,  // frame_last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [tfc_pkg::COLOUR_W-1:0]    m_axis_tdata,  // [15:0] colour_swapped
    output logic                                 m_axis_tlast   // frame_end
);
    import tfc_pkg::*;

    tfc_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] ref_low_reg, ref_low_next;
    logic [SAMPLE_BITS-1:0] ref_high_reg, ref_high_next;
    logic [SAMPLE_BITS-1:0] run_low_reg, run_low_next;
    logic [SAMPLE_BITS-1:0] run_high_reg, run_high_next;

    logic                   last_reg, last_next;
    logic [Q_W-1:0]         v_reg, v_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COLOUR_W-1:0]    out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic                   in_accept;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;
    logic                   range_ok;
    div_ctl_t               div_ctl;
    logic                   div_done;
    logic [Q_W-1:0]         div_q;
    logic [COLOUR_W-1:0]    colour;

    assign sample    = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // divider setup against the current (previous frame) reference
    always_comb
    begin
        range_ok           = (ref_high_reg > ref_low_reg);
        diff               = sample - ref_low_reg;
        span               = ref_high_reg - ref_low_reg;
        div_ctl.start      = in_accept;
        div_ctl.force_zero = !range_ok || (sample < ref_low_reg);
        div_ctl.force_max  = range_ok && (sample >= ref_low_reg) && (diff >= span);
    end

    tfc_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .numer    (diff),
        .denom    (span),
        .done     (div_done),
        .quotient (div_q)
    );

    tfc_colour u_colour (
        .v              (v_reg),
        .colour_swapped (colour)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DIV:  s_axis_tready = 1'b0;
            ST_OUT:  s_axis_tready = 1'b0;
            default: s_axis_tready = 1'b0;
        endcase
    end

    // running and reference low/high
    always_comb
    begin
        run_low_next  = run_low_reg;
        run_high_next = run_high_reg;
        ref_low_next  = ref_low_reg;
        ref_high_next = ref_high_reg;
        if (in_accept)
        begin
            if (sample < run_low_reg)
            begin
                run_low_next = sample;
            end
            if (sample > run_high_reg)
            begin
                run_high_next = sample;
            end
            if (s_axis_tlast)
            begin
                ref_low_next  = run_low_next;
                ref_high_next = run_high_next;
                run_low_next  = '1;
                run_high_next = '0;
            end
        end
    end

    // item payload and output register
    always_comb
    begin
        last_next      = in_accept ? s_axis_tlast : last_reg;
        v_next         = div_done ? div_q : v_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = colour;
            out_last_next  = last_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_low_reg   <= '0;
            ref_high_reg  <= '0;
            run_low_reg   <= '1;
            run_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_low_reg   <= ref_low_next;
            ref_high_reg  <= ref_high_next;
            run_low_reg   <= run_low_next;
            run_high_reg  <= run_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("output load did not present a result");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_DIV && !s_axis_tready))
        else $error("accepted item did not start the divider");
`endif

endmodule
`default_nettype wire

[rtl/core/tfc_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_divider: bit-serial restoring divider
// Computes (numer * 256) / denom for numer < denom, one quotient bit per
// cycle into a shift register; forced results still run every step.
// ----------------------------------------------------------------------------
module tfc_divider #(
    parameter int SAMPLE_BITS = tfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tfc_pkg::div_ctl_t        ctl,
    input  wire logic [SAMPLE_BITS-1:0]   numer,
    input  wire logic [SAMPLE_BITS-1:0]   denom,
    output logic                          done,
    output logic [tfc_pkg::Q_W-1:0]       quotient
);
    import tfc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] den_reg, den_next;
    logic [Q_W-1:0]         quo_reg, quo_next;
    logic                   fz_reg, fz_next;
    logic                   fm_reg, fm_next;

    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;

    // one restoring step: shift remainder, trial subtract
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        trial   = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // control next state
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath next state
    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        fz_next  = fz_reg;
        fm_next  = fm_reg;
        if (ctl.start)
        begin
            rem_next = numer;
            den_next = denom;
            quo_next = '0;
            fz_next  = ctl.force_zero;
            fm_next  = ctl.force_max;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        fz_reg  <= fz_next;
        fm_reg  <= fm_next;
    end

    // result, with clamps applied
    assign done     = done_reg;
    assign quotient = fz_reg ? '0 : (fm_reg ? Q_MAX : quo_reg);

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !ctl.start && cnt_reg == CNT_LAST) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !fz_reg && !fm_reg) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

[rtl/core/tfc_colour.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfc_colour: scaled value to byte-swapped RGB565
// Blue/green/red ramps, 8-bit to 5/6-bit rescale, pack and byte swap.
// ----------------------------------------------------------------------------
module tfc_colour (
    input  wire logic [tfc_pkg::Q_W-1:0]      v,
    output logic      [tfc_pkg::COLOUR_W-1:0] colour_swapped
);
    import tfc_pkg::*;

    localparam logic [8:0] MID = 9'd128;

    logic [8:0]  v9;
    logic [8:0]  red;
    logic [8:0]  blue;
    logic [8:0]  green;
    logic [8:0]  mid_dist;
    logic [15:0] r_prod;
    logic [15:0] g_prod;
    logic [15:0] b_prod;
    logic [15:0] r_q;
    logic [15:0] g_q;
    logic [15:0] b_q;
    logic [15:0] c;

    // x / 255 for x below 65280, shift-and-add form
    function automatic logic [15:0] div255(input logic [15:0] x);
        logic [15:0] s;
        s = x + (x >> 8) + 16'd1;
        return s >> 8;
    endfunction

    always_comb
    begin
        v9 = {1'b0, v};

        // ramps
        red  = (v9 > MID) ? ((v9 - MID) << 1) : 9'd0;
        if (red > 9'd255)
        begin
            red = 9'd255;
        end
        blue = (v9 < MID) ? ((MID - v9) << 1) : 9'd0;
        if (blue > 9'd255)
        begin
            blue = 9'd255;
        end
        mid_dist = (v9 >= MID) ? (v9 - MID) : (MID - v9);
        green    = (MID - mid_dist) << 1;

        // 31*(r+4), 63*(g+2), 31*(b+4) by shift and subtract
        r_prod = ((16'(red)   + 16'd4) << 5) - (16'(red)   + 16'd4);
        g_prod = ((16'(green) + 16'd2) << 6) - (16'(green) + 16'd2);
        b_prod = ((16'(blue)  + 16'd4) << 5) - (16'(blue)  + 16'd4);

        r_q = div255(r_prod);
        g_q = div255(g_prod);
        b_q = div255(b_prod);

        // pack RGB565 and swap bytes
        c = {r_q[4:0], g_q[5:0], b_q[4:0]};
        colour_swapped = {c[7:0], c[15:8]};
    end

endmodule
`default_nettype wire
